>>> rtl/sltu_pkg.sv
`default_nettype none
package sltu_pkg;
	localparam int VAL_W     = 32;
	localparam int RATE_W    = 16;
	localparam int STATE_W   = 6;
	localparam int ACTION_W  = 3;
	localparam int PROD1_W   = VAL_W + RATE_W + 1;
	localparam int RND_W     = VAL_W + 1;
	localparam int DELTA_W   = VAL_W + 3;
	localparam int PROD2_W   = DELTA_W + RATE_W + 1;
	localparam int AD_W      = DELTA_W;
	localparam int SUM_W     = AD_W + RATE_W + 2;
	localparam int ROUND_HALF = 32768;

	localparam logic [VAL_W-1:0] TRACE_ONE = 32'h0001_0000;
	localparam logic [VAL_W-1:0] TRACE_MAX = 32'h7FFF_FFFF;

	localparam logic OP_EPISODE = 1'b0;
	localparam logic OP_READ    = 1'b1;

	localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
	localparam logic [1:0] REG_DISCOUNT      = 2'd1;
	localparam logic [1:0] REG_TRACE_DECAY   = 2'd2;
	localparam logic [1:0] REG_PENALTY       = 2'd3;

	localparam logic [1:0] EP_NONE   = 2'd0;
	localparam logic [1:0] EP_FIRST  = 2'd1;
	localparam logic [1:0] EP_SECOND = 2'd2;
	localparam logic [1:0] EP_LATER  = 2'd3;

	typedef struct packed {
		logic                    start;
		logic signed [AD_W-1:0]  ad;
		logic [RATE_W-1:0]       g;
	} sweep_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sweep_stat_t;

	function automatic logic signed [VAL_W-1:0] sat_wide(input logic signed [63:0] x);
		logic signed [VAL_W-1:0] r;
		if (x > 64'sh0000_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (x < -64'sh0000_0000_8000_0000)
			r = 32'sh8000_0000;
		else
			r = x[VAL_W-1:0];
		return r;
	endfunction
endpackage
`default_nettype wire

>>> rtl/sltu_in_if.sv
`default_nettype none
interface sltu_in_if;
	import sltu_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       operation;
	logic [STATE_W-1:0]         observed_state;
	logic [ACTION_W-1:0]        observed_action;
	logic signed [VAL_W-1:0]    observed_reward;
	logic                       punish;
	modport source(output valid, operation, observed_state, observed_action,
		observed_reward, punish, input ready);
	modport sink(input valid, operation, observed_state, observed_action,
		observed_reward, punish, output ready);
endinterface
`default_nettype wire

>>> rtl/sltu_out_if.sv
`default_nettype none
interface sltu_out_if;
	import sltu_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] table_value;
	logic                    did_update;
	modport source(output valid, table_value, did_update, input ready);
	modport sink(input valid, table_value, did_update, output ready);
endinterface
`default_nettype wire

>>> rtl/sltu_mem.sv
`default_nettype none
module sltu_mem #(
	parameter int DEPTH = 512,
	parameter int W = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic [W-1:0]       rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [W-1:0]  wr_data
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

>>> rtl/sltu_sweep.sv
`default_nettype none
module sltu_sweep #(
	parameter int DEPTH = 512,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire sltu_pkg::sweep_cmd_t     cmd,
	input  wire logic [AW-1:0]            target,
	input  wire logic [sltu_pkg::VAL_W-1:0] q_rdata,
	input  wire logic [sltu_pkg::VAL_W-1:0] e_rdata,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic [sltu_pkg::VAL_W-1:0]    q_wdata,
	output logic [sltu_pkg::VAL_W-1:0]    e_wdata,
	output sltu_pkg::sweep_stat_t         stat,
	output logic [sltu_pkg::VAL_W-1:0]    target_value
);
	import sltu_pkg::*;

	logic                    running_q;
	logic [AW:0]             rd_cnt_q;
	logic signed [AD_W-1:0]  ad_q;
	logic [RATE_W-1:0]       g_q;
	logic                    done_q;
	logic [VAL_W-1:0]        tv_q;

	logic                    v_s1;
	logic [AW-1:0]           idx_s1;
	logic                    v_s2;
	logic [AW-1:0]           idx_s2;
	logic signed [VAL_W-1:0] q_s2;
	logic signed [PROD2_W-1:0] ph_s2;
	logic signed [PROD2_W-1:0] pl_s2;
	logic [VAL_W+RATE_W-1:0] pe_s2;
	logic                    v_s3;
	logic [AW-1:0]           idx_s3;
	logic signed [VAL_W-1:0] q_s3;
	logic signed [PROD2_W:0] inc_s3;
	logic [VAL_W-1:0]        e_s3;

	logic signed [PROD2_W:0] inc_c;
	logic [VAL_W+RATE_W:0]   pe_rnd;
	logic signed [PROD2_W+1:0] q_sum;
	logic                    last_rd;

	assign rd_en   = running_q;
	assign rd_addr = rd_cnt_q[AW-1:0];
	assign last_rd = rd_cnt_q == (AW+1)'(DEPTH - 1);

	assign inc_c  = ph_s2 + ((pl_s2 + ROUND_HALF) >>> 16);
	assign pe_rnd = {1'b0, pe_s2} + (VAL_W+RATE_W+1)'(ROUND_HALF);
	assign q_sum  = q_s3 + inc_s3;

	assign wr_en   = v_s3;
	assign wr_addr = idx_s3;
	assign q_wdata = sat_wide(64'(q_sum));
	assign e_wdata = e_s3;

	assign stat.busy    = running_q | v_s1 | v_s2 | v_s3;
	assign stat.done    = done_q;
	assign target_value = tv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			rd_cnt_q  <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			v_s1   <= running_q;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3 && idx_s3 == AW'(DEPTH - 1);
			if (cmd.start) begin
				running_q <= 1'b1;
				rd_cnt_q  <= '0;
			end else if (running_q) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
				if (last_rd)
					running_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ad_q <= cmd.ad;
			g_q  <= cmd.g;
		end
		idx_s1 <= rd_addr;
		idx_s2 <= idx_s1;
		q_s2   <= $signed(q_rdata);
		ph_s2  <= ad_q * $signed({1'b0, e_rdata[VAL_W-1:RATE_W]});
		pl_s2  <= ad_q * $signed({1'b0, e_rdata[RATE_W-1:0]});
		pe_s2  <= g_q * e_rdata;
		idx_s3 <= idx_s2;
		q_s3   <= q_s2;
		inc_s3 <= inc_c;
		e_s3   <= pe_rnd[VAL_W+RATE_W-1:RATE_W];
		if (v_s3 && idx_s3 == target)
			tv_q <= q_wdata;
	end

	property p_no_restart;
		@(posedge clk) disable iff (!arst_n) cmd.start |-> !stat.busy;
	endproperty
	a_no_restart: assert property (p_no_restart) else $error("sweep restarted while busy");

	property p_done_after_write;
		@(posedge clk) disable iff (!arst_n) done_q |-> $past(v_s3);
	endproperty
	a_done_after_write: assert property (p_done_after_write) else $error("done without write");

	property p_pipe_follow;
		@(posedge clk) disable iff (!arst_n) v_s2 |=> v_s3;
	endproperty
	a_pipe_follow: assert property (p_pipe_follow) else $error("pipeline word lost");
endmodule
`default_nettype wire

>>> rtl/sarsa_lambda_table_update.sv
`default_nettype none
// SARSA(lambda) table learner.
// Channels: item (sink) carries one decision episode or one table read;
// result (source) returns one word per item: the updated or read Q16.16
// value and a did_update flag. Both use valid/ready; a word moves when
// both are high. cfg_en/cfg_index/cfg_data write the four rate and
// penalty registers; write them only while no item is open.
// Items are taken one at a time; item.ready is high only between items.
// Path from accept to result: the first two episodes go straight to the
// result register; a read reads the value table; a one-step update reads
// both values and forms delta, alpha*delta and the new value; a trace update
// then bumps the trace and runs the sweep over every pair of both tables,
// one pair per cycle through the shared read port of each memory. The next
// item is taken after the word is posted. Reset sets the control and rate
// registers and clears both memories in one pass; items wait until it ends.
// A stalled receiver holds the result word in the output register; the
// next item is accepted meanwhile and waits only to post its own word.
module sarsa_lambda_table_update #(
	parameter int STATE_COUNT = 64,
	parameter int ACTION_COUNT = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	sltu_in_if.sink                        item,
	sltu_out_if.source                     result,
	input  wire logic                      cfg_en,
	input  wire logic [1:0]                cfg_index,
	input  wire logic [sltu_pkg::VAL_W-1:0] cfg_data
);
	import sltu_pkg::*;

	localparam int TABLE_N = STATE_COUNT * ACTION_COUNT;
	localparam int AW  = $clog2(TABLE_N);
	localparam int SW  = $clog2(STATE_COUNT);
	localparam int ACW = $clog2(ACTION_COUNT);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_RDV  = 4'd2;
	localparam logic [3:0] ST_QS   = 4'd3;
	localparam logic [3:0] ST_QN   = 4'd4;
	localparam logic [3:0] ST_DEL  = 4'd5;
	localparam logic [3:0] ST_ALR  = 4'd6;
	localparam logic [3:0] ST_AD   = 4'd7;
	localparam logic [3:0] ST_UPD  = 4'd8;
	localparam logic [3:0] ST_ETR  = 4'd9;
	localparam logic [3:0] ST_SWP  = 4'd10;
	localparam logic [3:0] ST_RES  = 4'd11;

	logic [3:0]              state_q;
	logic [AW:0]             clr_cnt_q;
	logic [RATE_W-1:0]       lr_q;
	logic [RATE_W-1:0]       disc_q;
	logic [RATE_W-1:0]       lambda_q;
	logic signed [VAL_W-1:0] penalty_q;
	logic [1:0]              ep_q;
	logic [SW-1:0]           cs_q;
	logic [ACW-1:0]          ca_q;
	logic [SW-1:0]           fs_q;
	logic signed [VAL_W-1:0] pr_q;
	logic                    out_valid_q;
	logic [VAL_W-1:0]        out_value_q;
	logic                    out_upd_q;

	logic [AW-1:0]             si_q;
	logic [AW-1:0]             ni_q;
	logic signed [VAL_W-1:0]   upd_pr_q;
	logic signed [VAL_W-1:0]   qs_q;
	logic signed [PROD1_W-1:0] prod1_q;
	logic signed [DELTA_W-1:0] delta_q;
	logic signed [PROD2_W-1:0] prod2_q;
	logic signed [AD_W-1:0]    ad_q;
	logic [RATE_W-1:0]         g_q;
	logic [VAL_W-1:0]          res_value_q;
	logic                      res_upd_q;

	logic [SW-1:0]  s_map [2**STATE_W];
	logic [ACW-1:0] a_map [2**ACTION_W];
	logic [SW-1:0]  s_red;
	logic [ACW-1:0] a_red;
	logic [SW-1:0]  fs_new;
	logic [AW-1:0]  idx_in;
	logic [AW-1:0]  si_new;
	logic [AW-1:0]  ni_new;
	logic           accept;
	logic           out_free;
	logic           clr_last;

	logic signed [RND_W-1:0] rnd_c;
	logic signed [AD_W-1:0]  ad_c;
	logic signed [AD_W:0]    qs_sum;
	logic [VAL_W-1:0]        up_new;
	logic [VAL_W:0]          g_prod;
	logic [VAL_W:0]          e_inc;
	logic [VAL_W-1:0]        e_new;

	logic             v_rd_en, v_wr_en, t_rd_en, t_wr_en;
	logic [AW-1:0]    v_rd_addr, v_wr_addr, t_rd_addr, t_wr_addr;
	logic [VAL_W-1:0] v_wdata, t_wdata, v_rdata, t_rdata;

	sweep_cmd_t       sw_cmd;
	sweep_stat_t      sw_stat;
	logic             sw_rd_en, sw_wr_en;
	logic [AW-1:0]    sw_rd_addr, sw_wr_addr;
	logic [VAL_W-1:0] sw_q_wdata, sw_e_wdata, sw_target;

	// index reduction tables, built at elaboration
	for (genvar i = 0; i < 2**STATE_W; i++) begin : g_smap
		assign s_map[i] = SW'(i % STATE_COUNT);
	end
	for (genvar i = 0; i < 2**ACTION_W; i++) begin : g_amap
		assign a_map[i] = ACW'(i % ACTION_COUNT);
	end

	assign s_red  = s_map[item.observed_state];
	assign a_red  = a_map[item.observed_action];
	assign fs_new = (ep_q == EP_LATER) ? s_red : fs_q;
	assign idx_in = AW'(s_red) * AW'(ACTION_COUNT) + AW'(a_red);
	assign si_new = AW'(cs_q) * AW'(ACTION_COUNT) + AW'(ca_q);
	assign ni_new = AW'(fs_new) * AW'(ACTION_COUNT) + AW'(a_red);

	assign item.ready = state_q == ST_IDLE;
	assign accept     = item.valid & item.ready;
	assign out_free   = !out_valid_q || result.ready;
	assign clr_last   = clr_cnt_q == (AW+1)'(TABLE_N - 1);

	assign result.valid       = out_valid_q;
	assign result.table_value = out_value_q;
	assign result.did_update  = out_upd_q;

	assign rnd_c  = RND_W'((prod1_q + ROUND_HALF) >>> 16);
	assign ad_c   = AD_W'((prod2_q + ROUND_HALF) >>> 16);
	assign qs_sum = qs_q + ad_q;
	assign up_new = sat_wide(64'(qs_sum));
	assign g_prod = (VAL_W+1)'(disc_q) * (VAL_W+1)'(lambda_q) + (VAL_W+1)'(ROUND_HALF);
	assign e_inc  = {1'b0, t_rdata} + {1'b0, TRACE_ONE};
	assign e_new  = (e_inc > {1'b0, TRACE_MAX}) ? TRACE_MAX : e_inc[VAL_W-1:0];

	assign sw_cmd.start = state_q == ST_ETR;
	assign sw_cmd.ad    = ad_q;
	assign sw_cmd.g     = g_q;

	always_comb begin
		v_rd_en   = 1'b0;
		v_rd_addr = si_q;
		v_wr_en   = 1'b0;
		v_wr_addr = si_q;
		v_wdata   = up_new;
		t_rd_en   = 1'b0;
		t_rd_addr = si_q;
		t_wr_en   = 1'b0;
		t_wr_addr = si_q;
		t_wdata   = e_new;
		case (state_q)
			ST_CLR: begin
				v_wr_en   = 1'b1;
				v_wr_addr = clr_cnt_q[AW-1:0];
				v_wdata   = '0;
				t_wr_en   = 1'b1;
				t_wr_addr = clr_cnt_q[AW-1:0];
				t_wdata   = '0;
			end
			ST_IDLE: begin
				v_rd_en   = accept;
				v_rd_addr = (item.operation == OP_READ) ? idx_in : si_new;
			end
			ST_QS: begin
				v_rd_en   = 1'b1;
				v_rd_addr = ni_q;
			end
			ST_UPD: begin
				v_wr_en = lambda_q == '0;
				t_rd_en = lambda_q != '0;
			end
			ST_ETR: begin
				t_wr_en = 1'b1;
			end
			ST_SWP: begin
				v_rd_en   = sw_rd_en;
				v_rd_addr = sw_rd_addr;
				t_rd_en   = sw_rd_en;
				t_rd_addr = sw_rd_addr;
				v_wr_en   = sw_wr_en;
				v_wr_addr = sw_wr_addr;
				v_wdata   = sw_q_wdata;
				t_wr_en   = sw_wr_en;
				t_wr_addr = sw_wr_addr;
				t_wdata   = sw_e_wdata;
			end
			default: begin
			end
		endcase
	end

	sltu_mem #(.DEPTH(TABLE_N), .W(VAL_W)) u_value_mem (
		.clk(clk), .rd_en(v_rd_en), .rd_addr(v_rd_addr), .rd_data(v_rdata),
		.wr_en(v_wr_en), .wr_addr(v_wr_addr), .wr_data(v_wdata)
	);

	sltu_mem #(.DEPTH(TABLE_N), .W(VAL_W)) u_trace_mem (
		.clk(clk), .rd_en(t_rd_en), .rd_addr(t_rd_addr), .rd_data(t_rdata),
		.wr_en(t_wr_en), .wr_addr(t_wr_addr), .wr_data(t_wdata)
	);

	sltu_sweep #(.DEPTH(TABLE_N)) u_sweep (
		.clk(clk), .arst_n(arst_n), .cmd(sw_cmd), .target(si_q),
		.q_rdata(v_rdata), .e_rdata(t_rdata),
		.rd_en(sw_rd_en), .rd_addr(sw_rd_addr),
		.wr_en(sw_wr_en), .wr_addr(sw_wr_addr),
		.q_wdata(sw_q_wdata), .e_wdata(sw_e_wdata),
		.stat(sw_stat), .target_value(sw_target)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_cnt_q   <= '0;
			lr_q        <= 16'd6554;
			disc_q      <= 16'd58982;
			lambda_q    <= '0;
			penalty_q   <= '0;
			ep_q        <= EP_NONE;
			cs_q        <= '0;
			ca_q        <= '0;
			fs_q        <= '0;
			pr_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_en) begin
				case (cfg_index)
					REG_LEARNING_RATE: lr_q      <= cfg_data[RATE_W-1:0];
					REG_DISCOUNT:      disc_q    <= cfg_data[RATE_W-1:0];
					REG_TRACE_DECAY:   lambda_q  <= cfg_data[RATE_W-1:0];
					REG_PENALTY:       penalty_q <= $signed(cfg_data);
					default: begin
					end
				endcase
			end
			if (state_q == ST_RES && out_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_last)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						if (item.operation == OP_READ) begin
							state_q <= ST_RDV;
						end else begin
							case (ep_q)
								EP_NONE: begin
									cs_q    <= s_red;
									ep_q    <= EP_FIRST;
									state_q <= ST_RES;
								end
								EP_FIRST: begin
									ca_q    <= a_red;
									pr_q    <= item.observed_reward;
									fs_q    <= s_red;
									ep_q    <= EP_SECOND;
									state_q <= ST_RES;
								end
								default: begin
									// latch the next pair now; the datapath holds its own copies
									fs_q    <= fs_new;
									cs_q    <= fs_new;
									ca_q    <= a_red;
									pr_q    <= item.observed_reward;
									ep_q    <= EP_LATER;
									state_q <= ST_QS;
								end
							endcase
						end
					end
				end
				ST_RDV:  state_q <= ST_RES;
				ST_QS:   state_q <= ST_QN;
				ST_QN:   state_q <= ST_DEL;
				ST_DEL:  state_q <= ST_ALR;
				ST_ALR:  state_q <= ST_AD;
				ST_AD:   state_q <= ST_UPD;
				ST_UPD:  state_q <= (lambda_q == '0) ? ST_RES : ST_ETR;
				ST_ETR:  state_q <= ST_SWP;
				ST_SWP: begin
					if (sw_stat.done)
						state_q <= ST_RES;
				end
				ST_RES: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_value_q <= '0;
				res_upd_q   <= 1'b0;
				si_q        <= si_new;
				ni_q        <= ni_new;
				upd_pr_q    <= item.punish ? penalty_q : pr_q;
			end
			ST_RDV: begin
				res_value_q <= v_rdata;
			end
			ST_QS:  qs_q    <= $signed(v_rdata);
			ST_QN:  prod1_q <= $signed(v_rdata) * $signed({1'b0, disc_q});
			ST_DEL: begin
				delta_q <= upd_pr_q + rnd_c - qs_q;
				g_q     <= g_prod[VAL_W-1:RATE_W];
			end
			ST_ALR: prod2_q <= delta_q * $signed({1'b0, lr_q});
			ST_AD:  ad_q    <= ad_c;
			ST_UPD: begin
				res_value_q <= up_new;
				res_upd_q   <= 1'b1;
			end
			ST_SWP: begin
				res_value_q <= sw_target;
				res_upd_q   <= 1'b1;
			end
			ST_RES: begin
				if (out_free) begin
					out_value_q <= res_value_q;
					out_upd_q   <= res_upd_q;
				end
			end
			default: begin
			end
		endcase
	end

	property p_clear_blocks;
		@(posedge clk) disable iff (!arst_n) state_q == ST_CLR |-> !item.ready;
	endproperty
	a_clear_blocks: assert property (p_clear_blocks) else $error("item taken during clear");

	property p_done_in_sweep;
		@(posedge clk) disable iff (!arst_n) sw_stat.done |-> state_q == ST_SWP;
	endproperty
	a_done_in_sweep: assert property (p_done_in_sweep) else $error("stray sweep done");

	property p_read_path;
		@(posedge clk) disable iff (!arst_n)
			accept && item.operation == OP_READ |=> state_q == ST_RDV;
	endproperty
	a_read_path: assert property (p_read_path) else $error("read item misrouted");

	property p_hold_stalled;
		@(posedge clk) disable iff (!arst_n)
			out_valid_q && !result.ready |=> $stable(out_value_q) && out_valid_q;
	endproperty
	a_hold_stalled: assert property (p_hold_stalled) else $error("stalled word changed");

	property p_episode_sticks;
		@(posedge clk) disable iff (!arst_n) ep_q != EP_NONE |=> ep_q != EP_NONE;
	endproperty
	a_episode_sticks: assert property (p_episode_sticks) else $error("episode count fell back");
endmodule
`default_nettype wire
